// ----- sv/ffmt_pkg.sv -----
// ----------------------------------------------------------------------------
// ffmt_pkg
// Shared types, constants and helpers of the first-fit max tree allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffmt_pkg;

    localparam int MAX_SLOTS  = 1024;
    localparam int CAP_WIDTH  = 32;
    localparam int LEVELS     = $clog2(MAX_SLOTS);
    localparam int NODE_W     = LEVELS + 1;
    localparam int TREE_DEPTH = 2 * MAX_SLOTS;
    localparam int ENTRY_W    = CAP_WIDTH + 1;
    localparam int DEPTH_W    = $clog2(LEVELS + 2);
    localparam int AMT_W      = 32;
    localparam int NEED_W     = AMT_W + 1;
    localparam int SLOT_W     = 10;
    localparam int CNT_W      = 32;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    localparam logic [63:0] CAP_MAX64 = (64'd1 << CAP_WIDTH) - 64'd1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PLACE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_DOWN,
        S_PUSH,
        S_UP
    } t_state;

    // lowest leaf index covered by heap node at the given depth
    function automatic logic [LEVELS-1:0] node_start(input logic [NODE_W-1:0] node,
                                                     input logic [DEPTH_W-1:0] depth);
        logic [2*LEVELS:0] t;
        t = {{LEVELS{1'b0}}, node} << (LEVELS - int'(depth));
        return t[LEVELS-1:0];
    endfunction

    // saturated capacity plus one
    function automatic logic [ENTRY_W-1:0] cap_entry(input logic [AMT_W-1:0] amount);
        logic [63:0] a;
        a = 64'(amount);
        if (a > CAP_MAX64) begin
            a = CAP_MAX64;
        end
        return ENTRY_W'(a + 64'd1);
    endfunction

endpackage

`default_nettype wire

// ----- sv/ffmt_ram.sv -----
// ----------------------------------------------------------------------------
// ffmt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ffmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- sv/first_fit_max_tree_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_max_tree_allocator
// First-fit slot allocator over a heap-ordered max tree held in one RAM.
// ----------------------------------------------------------------------------
// Load: accept, then LEVELS+1 leaf-to-root writes, one per tree level.
// Place: one RAM read per tree level going down, then, if placed, one read and
//   write per level going up.
// Failed place: the root read shows no fit, so the result is given with no descent.
// Reset: synchronous, active low; the load count masks never-written nodes,
//   so the tree is empty at once with no clearing pass.
`default_nettype none

module first_fit_max_tree_allocator
    import ffmt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // [31:0] amount
    input  wire logic                  i_s_axis_tuser,  // [0] mode
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic      [OUT_DATA_W-1:0] o_m_axis_tdata,  // [9:0] slot_index, [41:10] unplaced_total
    output logic                       o_m_axis_tuser   // [0] placed
);

    t_state                    r_state, n_state;
    logic [NODE_W-1:0]         r_node, n_node;
    logic [DEPTH_W-1:0]        r_depth, n_depth;
    logic [ENTRY_W-1:0]        r_val, n_val;
    logic                      r_first, n_first;
    logic [NEED_W-1:0]         r_need, n_need;
    logic                      r_placed, n_placed;
    logic                      r_rd_ok, n_rd_ok;
    logic [NODE_W-1:0]         r_loaded, n_loaded;
    logic [CNT_W-1:0]          r_fail, n_fail;
    logic                      r_out_valid, n_out_valid;
    logic                      r_out_placed, n_out_placed;
    logic [SLOT_W-1:0]         r_out_slot, n_out_slot;
    logic [CNT_W-1:0]          r_out_cnt, n_out_cnt;

    logic                      we;
    logic [NODE_W-1:0]         waddr;
    logic [ENTRY_W-1:0]        wdata;
    logic [NODE_W-1:0]         raddr;
    logic [DEPTH_W-1:0]        rd_depth;
    logic [ENTRY_W-1:0]        rdata;
    logic [ENTRY_W-1:0]        rd_val;
    logic                      ge;
    logic                      out_free;
    logic                      accept;
    logic [NODE_W-1:0]         nn;
    logic [CNT_W-1:0]          cnt_inc;

    ffmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TREE_DEPTH)
    ) u_tree (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_val   = r_rd_ok ? rdata : '0;
    assign ge       = 64'(rd_val) >= 64'(r_need);
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign nn       = {r_node[LEVELS-1:0], ~ge};
    assign cnt_inc  = (r_fail == '1) ? r_fail : r_fail + CNT_W'(1);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_placed;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - SLOT_W - CNT_W){1'b0}}, r_out_cnt, r_out_slot};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_s_axis_tuser == MODE_PLACE) begin
                        n_state = S_ROOT;
                    end else if (r_loaded < NODE_W'(MAX_SLOTS)) begin
                        n_state = S_UP;
                    end
                end
            end
            S_ROOT: begin
                n_state = ge ? S_DOWN : S_PUSH;
            end
            S_DOWN: begin
                if (r_depth == DEPTH_W'(LEVELS - 1)) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = r_placed ? S_UP : S_IDLE;
                end
            end
            S_UP: begin
                if (r_node == NODE_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_node       = r_node;
        n_depth      = r_depth;
        n_val        = r_val;
        n_first      = r_first;
        n_need       = r_need;
        n_placed     = r_placed;
        n_loaded     = r_loaded;
        n_fail       = r_fail;
        n_out_valid  = r_out_valid;
        n_out_placed = r_out_placed;
        n_out_slot   = r_out_slot;
        n_out_cnt    = r_out_cnt;
        we           = 1'b0;
        waddr        = r_node;
        wdata        = r_val;
        raddr        = NODE_W'(1);
        rd_depth     = '0;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_s_axis_tuser == MODE_PLACE) begin
                        raddr   = NODE_W'(1);
                        n_need  = NEED_W'(i_s_axis_tdata[AMT_W-1:0]) + NEED_W'(1);
                        n_node  = NODE_W'(1);
                        n_depth = '0;
                    end else if (r_loaded < NODE_W'(MAX_SLOTS)) begin
                        n_node   = NODE_W'(MAX_SLOTS) + r_loaded;
                        n_depth  = DEPTH_W'(LEVELS);
                        n_val    = cap_entry(i_s_axis_tdata[AMT_W-1:0]);
                        n_first  = 1'b1;
                        n_loaded = r_loaded + NODE_W'(1);
                    end
                end
            end
            S_ROOT: begin
                n_placed = ge;
                raddr    = NODE_W'(2);
                rd_depth = DEPTH_W'(1);
            end
            S_DOWN: begin
                n_node   = nn;
                n_depth  = r_depth + DEPTH_W'(1);
                raddr    = {nn[LEVELS-1:0], 1'b0};
                rd_depth = r_depth + DEPTH_W'(2);
            end
            S_PUSH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_placed = r_placed;
                    if (r_placed) begin
                        n_out_slot = SLOT_W'(r_node[LEVELS-1:0]);
                        n_out_cnt  = r_fail;
                        n_val      = '0;
                        n_first    = 1'b1;
                    end else begin
                        n_out_slot = '0;
                        n_out_cnt  = cnt_inc;
                        n_fail     = cnt_inc;
                    end
                end
            end
            S_UP: begin
                we       = 1'b1;
                waddr    = r_node;
                wdata    = (r_first || r_val > rd_val) ? r_val : rd_val;
                raddr    = r_node ^ NODE_W'(1);
                rd_depth = r_depth;
                n_val    = wdata;
                n_first  = 1'b0;
                if (r_node != NODE_W'(1)) begin
                    n_node  = r_node >> 1;
                    n_depth = r_depth - DEPTH_W'(1);
                end
            end
            default: begin
            end
        endcase

        n_rd_ok = {1'b0, node_start(raddr, rd_depth)} < n_loaded;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_loaded    <= '0;
            r_fail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_loaded    <= n_loaded;
            r_fail      <= n_fail;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node       <= n_node;
        r_depth      <= n_depth;
        r_val        <= n_val;
        r_first      <= n_first;
        r_need       <= n_need;
        r_placed     <= n_placed;
        r_rd_ok      <= n_rd_ok;
        r_out_placed <= n_out_placed;
        r_out_slot   <= n_out_slot;
        r_out_cnt    <= n_out_cnt;
    end

endmodule

`default_nettype wire

// ----- sv/ffmt_checker.sv -----
// ----------------------------------------------------------------------------
// ffmt_checker
// Port-level assertions for the first-fit max tree allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module ffmt_checker
    import ffmt_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input wire logic                  i_s_axis_tuser,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input wire logic                  o_m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output transaction changed while stalled");

    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[SLOT_W-1:0] == '0)
        else $error("failed placement carries a nonzero slot index");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_place_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == MODE_PLACE
            |=> !o_s_axis_tready)
        else $error("ready right after a place transaction");

endmodule

bind first_fit_max_tree_allocator ffmt_checker u_ffmt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
